// File: rtl/cbq_pkg.sv
// Shared types and constants for the cascaded biquad filter.
package cbq_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int COEFF_BITS  = 24;
	localparam int COEF_FRAC   = COEFF_BITS - 4;
	localparam int NUM_COEF    = 5;
	localparam int PROD_W      = SAMPLE_BITS + COEFF_BITS;
	localparam int ACC_W       = PROD_W + 3;
	localparam int CFG_ADDR_W  = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int STAGES_W    = 5;

	localparam logic [2:0] SLOT_A0 = 3'd0;
	localparam logic [2:0] SLOT_A1 = 3'd1;
	localparam logic [2:0] SLOT_A2 = 3'd2;
	localparam logic [2:0] SLOT_B1 = 3'd3;
	localparam logic [2:0] SLOT_B2 = 3'd4;

	localparam logic MODE_FILTER = 1'b0;
	localparam logic MODE_COEF   = 1'b1;

	localparam logic REG_STAGES_IN_USE = 1'b0;

	typedef struct packed {
		logic                          mode;
		logic signed [SAMPLE_BITS-1:0] sample_in;
		logic [3:0]                    coeff_stage;
		logic [2:0]                    coeff_slot;
		logic signed [COEFF_BITS-1:0]  coeff_value;
	} cbq_in_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_out;
		logic                          saturated;
	} cbq_out_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] x1;
		logic signed [SAMPLE_BITS-1:0] x2;
		logic signed [SAMPLE_BITS-1:0] y1;
		logic signed [SAMPLE_BITS-1:0] y2;
	} cbq_row_t;

	typedef struct packed {
		logic       start;
		logic       coef_wr;
		logic       mac;
		logic [2:0] slot;
		logic       coef_rd;
		logic       finish;
		logic       next_stage;
		logic       load_out;
	} cbq_cmd_t;

	typedef struct packed {
		logic out_full;
	} cbq_sts_t;

endpackage

// File: rtl/cascaded_biquad_iir_filter_top.sv
// Top level of the cascaded biquad filter with its register port.
//
// The input channel carries items of two kinds. A filter item (mode 0) sends
// one sample through stages 0 up to stages_in_use-1 (stage 0 alone if it is 0,
// all MAX_STAGES if it is larger) and gives one result on the output channel.
// A coefficient item (mode 1) writes one coefficient of one stage, unless its
// slot or stage is out of range, and gives no result.
// For each active stage a filter item takes five products on the one shared
// multiply-accumulate unit and one step to round, clip and update the stage
// delays; then the result is handed over, and only after that is the next
// item accepted.
// The result sits in an output register, so a new item is accepted while the
// receiver stalls; only a second result waits until the first is taken.
// Reset sets stages_in_use to 1 and makes every coefficient and every stage
// delay read as zero at once, with no clearing pass.
// stages_in_use sits at byte address 0 of the register port; the user must write
// it only while the block is idle, since the block does not enforce this.
module cascaded_biquad_iir_filter_top #(
	parameter int MAX_STAGES = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  cbq_pkg::cbq_in_t                in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output cbq_pkg::cbq_out_t               out_data,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [cbq_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [cbq_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [cbq_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                            pready
);
	import cbq_pkg::*;

	localparam int SW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

	logic [STAGES_W-1:0] stages_q;
	cbq_cmd_t            cmd;
	cbq_sts_t            sts;
	logic [SW-1:0]       stage;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stages_q <= STAGES_W'(1);
		end else if (psel && penable && pwrite && (paddr[2] == REG_STAGES_IN_USE)) begin
			stages_q <= pwdata[STAGES_W-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == REG_STAGES_IN_USE) begin
			prdata = CFG_DATA_W'(stages_q);
		end else begin
			prdata = '0;
		end
	end

	cbq_ctrl #(
		.MAX_STAGES(MAX_STAGES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (in_data.mode),
		.stages_cfg (stages_q),
		.out_ready  (out_ready),
		.sts        (sts),
		.cmd        (cmd),
		.stage      (stage)
	);

	cbq_dp #(
		.MAX_STAGES(MAX_STAGES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stage     (stage),
		.in_data   (in_data),
		.out_ready (out_ready),
		.sts       (sts),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

// File: rtl/cbq_ctrl.sv
// Sequencer that steps the shared multiply-accumulate unit through the stages.
module cbq_ctrl #(
	parameter int MAX_STAGES = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 mode,
	input  logic [cbq_pkg::STAGES_W-1:0]         stages_cfg,
	input  logic                                 out_ready,
	input  cbq_pkg::cbq_sts_t                    sts,
	output cbq_pkg::cbq_cmd_t                    cmd,
	output logic [(MAX_STAGES > 1 ? $clog2(MAX_STAGES) : 1)-1:0] stage
);
	import cbq_pkg::*;

	localparam int SW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_MAC    = 4'b0010,
		ST_FINISH = 4'b0100,
		ST_EMIT   = 4'b1000
	} state_t;

	state_t        state_q, state_d;
	logic [SW-1:0] stage_q, stage_d, stage_last;
	logic [2:0]    k_q, k_d;

	always_comb begin
		if (stages_cfg == '0) begin
			stage_last = '0;
		end else if (int'(stages_cfg) > MAX_STAGES) begin
			stage_last = SW'(MAX_STAGES - 1);
		end else begin
			stage_last = SW'(32'(stages_cfg) - 32'd1);
		end
	end

	always_comb begin
		state_d  = state_q;
		stage_d  = stage_q;
		k_d      = k_q;
		cmd      = '0;
		cmd.slot = k_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (mode == MODE_COEF) begin
						cmd.coef_wr = 1'b1;
					end else begin
						cmd.start = 1'b1;
						stage_d   = '0;
						k_d       = SLOT_A0;
						state_d   = ST_MAC;
					end
				end
			end
			ST_MAC: begin
				cmd.mac = 1'b1;
				if (k_q != SLOT_B2) begin
					cmd.coef_rd = 1'b1;
					k_d         = k_q + 3'd1;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				if (stage_q == stage_last) begin
					state_d = ST_EMIT;
				end else begin
					cmd.next_stage = 1'b1;
					stage_d        = stage_q + SW'(1);
					k_d            = SLOT_A0;
					state_d        = ST_MAC;
				end
			end
			ST_EMIT: begin
				if (!sts.out_full || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stage_q <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			stage_q <= stage_d;
			k_q     <= k_d;
		end
	end

	assign stage = stage_q;

endmodule

// File: rtl/cbq_dp.sv
// Datapath: coefficient and delay memories, multiply-accumulate, rounding and output register.
module cbq_dp #(
	parameter int MAX_STAGES = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cbq_pkg::cbq_cmd_t                    cmd,
	input  logic [(MAX_STAGES > 1 ? $clog2(MAX_STAGES) : 1)-1:0] stage,
	input  cbq_pkg::cbq_in_t                     in_data,
	input  logic                                 out_ready,
	output cbq_pkg::cbq_sts_t                    sts,
	output logic                                 out_valid,
	output cbq_pkg::cbq_out_t                    out_data
);
	import cbq_pkg::*;

	localparam int SW     = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
	localparam int CDEPTH = MAX_STAGES * NUM_COEF;
	localparam int CAW    = $clog2(CDEPTH);
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (COEF_FRAC - 1);
	localparam logic signed [ACC_W-1:0] SMAX =
		{{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SMIN = ~SMAX;

	logic signed [COEFF_BITS-1:0] cmem [CDEPTH];
	logic                         cvalid_q [CDEPTH];
	cbq_row_t                     rmem [MAX_STAGES];
	logic                         rvalid_q [MAX_STAGES];

	logic signed [COEFF_BITS-1:0]  coef_rd_q;
	logic                          coef_ok_q;
	cbq_row_t                      row_rd_q;
	logic                          row_ok_q;
	logic [CAW-1:0]                caddr_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [ACC_W-1:0]       acc_q;
	logic                          clip_q;
	logic                          out_valid_q;
	cbq_out_t                      out_q;

	logic                          wr_ok;
	logic [CAW-1:0]                waddr;
	logic [CAW-1:0]                craddr;
	logic                          crd_en;
	logic                          rrd_en;
	logic [SW-1:0]                 rraddr;
	logic signed [COEFF_BITS-1:0]  coef_eff;
	cbq_row_t                      row_eff;
	cbq_row_t                      row_new;
	logic signed [SAMPLE_BITS-1:0] opnd;
	logic signed [PROD_W-1:0]      prod;
	logic signed [ACC_W-1:0]       acc_base;
	logic signed [ACC_W-1:0]       acc_rnd;
	logic signed [ACC_W-1:0]       acc_shr;
	logic signed [SAMPLE_BITS-1:0] y;
	logic                          y_clip;

	assign wr_ok = cmd.coef_wr && (in_data.coeff_slot <= SLOT_B2)
		&& (int'(in_data.coeff_stage) < MAX_STAGES);
	assign waddr = CAW'({in_data.coeff_stage, 2'b00}) + CAW'(in_data.coeff_stage)
		+ CAW'(in_data.coeff_slot);
	assign crd_en = cmd.start || cmd.coef_rd || cmd.next_stage;
	assign craddr = cmd.start ? '0 : caddr_q;
	assign rrd_en = cmd.start || cmd.next_stage;
	assign rraddr = cmd.start ? '0 : stage + SW'(1);

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			cmem[waddr] <= in_data.coeff_value;
		end
		if (crd_en) begin
			coef_rd_q <= cmem[craddr];
		end
		if (cmd.finish) begin
			rmem[stage] <= row_new;
		end
		if (rrd_en) begin
			row_rd_q <= rmem[rraddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CDEPTH; i++) begin
				cvalid_q[i] <= 1'b0;
			end
			for (int i = 0; i < MAX_STAGES; i++) begin
				rvalid_q[i] <= 1'b0;
			end
			coef_ok_q   <= 1'b0;
			row_ok_q    <= 1'b0;
			caddr_q     <= '0;
			clip_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_ok) begin
				cvalid_q[waddr] <= 1'b1;
			end
			if (cmd.finish) begin
				rvalid_q[stage] <= 1'b1;
			end
			if (crd_en) begin
				coef_ok_q <= cvalid_q[craddr];
				caddr_q   <= craddr + CAW'(1);
			end
			if (rrd_en) begin
				row_ok_q <= rvalid_q[rraddr];
			end
			if (cmd.start) begin
				clip_q <= 1'b0;
			end else if (cmd.finish) begin
				clip_q <= clip_q | y_clip;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign coef_eff = coef_ok_q ? coef_rd_q : '0;
	assign row_eff  = row_ok_q ? row_rd_q : '0;

	always_comb begin
		unique case (cmd.slot)
			SLOT_A0: opnd = x_q;
			SLOT_A1: opnd = row_eff.x1;
			SLOT_A2: opnd = row_eff.x2;
			SLOT_B1: opnd = row_eff.y1;
			SLOT_B2: opnd = row_eff.y2;
			default: opnd = '0;
		endcase
	end

	assign prod     = coef_eff * opnd;
	assign acc_base = (cmd.slot == SLOT_A0) ? '0 : acc_q;
	assign acc_rnd  = acc_q + HALF;
	assign acc_shr  = acc_rnd >>> COEF_FRAC;

	always_comb begin
		if (acc_shr > SMAX) begin
			y      = SMAX[SAMPLE_BITS-1:0];
			y_clip = 1'b1;
		end else if (acc_shr < SMIN) begin
			y      = SMIN[SAMPLE_BITS-1:0];
			y_clip = 1'b1;
		end else begin
			y      = acc_shr[SAMPLE_BITS-1:0];
			y_clip = 1'b0;
		end
	end

	always_comb begin
		row_new.x1 = x_q;
		row_new.x2 = row_eff.x1;
		row_new.y1 = y;
		row_new.y2 = row_eff.y1;
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q <= in_data.sample_in;
		end else if (cmd.finish) begin
			x_q <= y;
		end
		if (cmd.mac) begin
			acc_q <= acc_base + ACC_W'(prod);
		end
		if (cmd.load_out) begin
			out_q.sample_out <= x_q;
			out_q.saturated  <= clip_q;
		end
	end

	assign sts.out_full = out_valid_q;
	assign out_valid    = out_valid_q;
	assign out_data     = out_q;

endmodule
